@@ rtl/bps_pkg.sv @@
// Shared types, constants and the battery filter function for the battery power sequencer.
// Depends on nothing; every other file of the block uses it by scoped names.
package bps_pkg;

    localparam int MV_W      = 16;
    localparam int LEVEL_W   = 10;
    localparam int COUNT_W   = 16;
    localparam int SECONDS_W = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Accumulator width for 15*old + new on 16-bit signed values.
    localparam int ACC_W = MV_W + 5;

    localparam logic signed [MV_W-1:0]    ON_THRESHOLD_RST    = 16'sd12000;
    localparam logic signed [MV_W-1:0]    OFF_THRESHOLD_RST   = 16'sd11000;
    localparam logic [MV_W-1:0]           STAY_ON_RST         = 16'd34463;
    localparam logic [LEVEL_W-1:0]        SWITCH_OFF_RST      = 10'd341;
    localparam logic [LEVEL_W-1:0]        SWITCH_ON_RST       = 10'd682;
    localparam logic [COUNT_W-1:0]        SHUTDOWN_RELOAD_RST = 16'd60;
    localparam logic [COUNT_W-1:0]        POWERUP_RELOAD_RST  = 16'd60;
    localparam logic [COUNT_W-1:0]        DEFAULT_DELAY_RST   = 16'd60;

    typedef enum logic [1:0] {
        KIND_TICK         = 2'd0,
        KIND_SAMPLE       = 2'd1,
        KIND_LOAD_SHUTDOWN = 2'd2,
        KIND_LOAD_POWERUP = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_OFF       = 2'd0,
        MODE_AUTO      = 2'd1,
        MODE_ALWAYS_ON = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ON_THRESHOLD    = 3'd0,
        REG_OFF_THRESHOLD   = 3'd1,
        REG_STAY_ON         = 3'd2,
        REG_SWITCH_OFF      = 3'd3,
        REG_SWITCH_ON       = 3'd4,
        REG_SHUTDOWN_RELOAD = 3'd5,
        REG_POWERUP_RELOAD  = 3'd6,
        REG_DEFAULT_DELAY   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [MV_W-1:0] on_threshold_mv;
        logic signed [MV_W-1:0] off_threshold_mv;
        logic [MV_W-1:0]        stay_on_threshold_mv;
        logic [LEVEL_W-1:0]     switch_off_limit;
        logic [LEVEL_W-1:0]     switch_on_limit;
        logic [COUNT_W-1:0]     shutdown_reload;
        logic [COUNT_W-1:0]     powerup_reload;
        logic [COUNT_W-1:0]     default_shutdown_delay;
    } cfg_t;

    // (15*old + new)/16 with truncation toward zero; the result always fits 16 bits.
    function automatic logic signed [MV_W-1:0] filter_step(
        input logic signed [MV_W-1:0] old_mv,
        input logic signed [MV_W-1:0] new_mv
    );
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] adj;
        acc = (ACC_W'(old_mv) <<< 4) - ACC_W'(old_mv) + ACC_W'(new_mv);
        adj = acc[ACC_W-1] ? acc + ACC_W'(15) : acc;
        return adj[MV_W+3:4];
    endfunction

endpackage

@@ rtl/bps_ifs.sv @@
// Request and result channel interfaces of the battery power sequencer.
// Depends on bps_pkg for field widths.
interface bps_item_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          kind;
    logic signed [bps_pkg::MV_W-1:0]     battery_mv;
    logic [bps_pkg::LEVEL_W-1:0]         switch_level;
    logic [bps_pkg::COUNT_W-1:0]         count_value;

    modport source (output valid, kind, battery_mv, switch_level, count_value, input ready);
    modport sink   (input valid, kind, battery_mv, switch_level, count_value, output ready);
endinterface

interface bps_result_if;
    logic                                valid;
    logic                                ready;
    logic                                power_on;
    logic [1:0]                          switch_mode;
    logic signed [bps_pkg::MV_W-1:0]     filtered_mv;
    logic [bps_pkg::COUNT_W-1:0]         shutdown_left;
    logic [bps_pkg::COUNT_W-1:0]         powerup_left;
    logic [bps_pkg::SECONDS_W-1:0]       seconds;

    modport source (output valid, power_on, switch_mode, filtered_mv, shutdown_left,
                    powerup_left, seconds, input ready);
    modport sink   (input valid, power_on, switch_mode, filtered_mv, shutdown_left,
                    powerup_left, seconds, output ready);
endinterface

@@ rtl/bps_cfg_regs.sv @@
// Configuration register file of the battery power sequencer.
// Depends on bps_pkg for the register layout and reset values.
module bps_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]    index,
    input  logic [bps_pkg::CFG_W-1:0]        wdata,
    output bps_pkg::cfg_t                    cfg
);

    bps_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_threshold_mv        <= bps_pkg::ON_THRESHOLD_RST;
            cfg_reg.off_threshold_mv       <= bps_pkg::OFF_THRESHOLD_RST;
            cfg_reg.stay_on_threshold_mv   <= bps_pkg::STAY_ON_RST;
            cfg_reg.switch_off_limit       <= bps_pkg::SWITCH_OFF_RST;
            cfg_reg.switch_on_limit        <= bps_pkg::SWITCH_ON_RST;
            cfg_reg.shutdown_reload        <= bps_pkg::SHUTDOWN_RELOAD_RST;
            cfg_reg.powerup_reload         <= bps_pkg::POWERUP_RELOAD_RST;
            cfg_reg.default_shutdown_delay <= bps_pkg::DEFAULT_DELAY_RST;
        end
        else if (we)
        begin
            unique case (bps_pkg::cfg_idx_t'(index))
                bps_pkg::REG_ON_THRESHOLD:    cfg_reg.on_threshold_mv <= $signed(wdata);
                bps_pkg::REG_OFF_THRESHOLD:   cfg_reg.off_threshold_mv <= $signed(wdata);
                bps_pkg::REG_STAY_ON:         cfg_reg.stay_on_threshold_mv <= wdata;
                bps_pkg::REG_SWITCH_OFF:
                    cfg_reg.switch_off_limit <= wdata[bps_pkg::LEVEL_W-1:0];
                bps_pkg::REG_SWITCH_ON:
                    cfg_reg.switch_on_limit <= wdata[bps_pkg::LEVEL_W-1:0];
                bps_pkg::REG_SHUTDOWN_RELOAD: cfg_reg.shutdown_reload <= wdata;
                bps_pkg::REG_POWERUP_RELOAD:  cfg_reg.powerup_reload <= wdata;
                bps_pkg::REG_DEFAULT_DELAY:   cfg_reg.default_shutdown_delay <= wdata;
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/battery_power_sequencer.sv @@
// Top level of the battery power sequencer: request register, state update and result.
// Depends on bps_pkg, the channel interfaces in bps_ifs.sv and bps_cfg_regs.
//
// The sequencer takes one request per clock cycle unless a result stalls, and returns exactly
// one result per request: the request is captured in an input register, and the
// small update logic (one 21-bit filter add, a few 10- and 16-bit compares and
// 16-bit decrements) then writes the sequencer state, which is also the result
// register. A tick request runs the shutdown or power-up countdown and the seconds
// counter; a sample request filters the battery level as (15*old+new)/16, classifies
// the mode switch and runs the on/off machine; the two load requests overwrite one
// countdown. Each result shows the visible state after its request. A result waiting
// for the consumer stalls the input register only; while results are taken every
// cycle, a new request is accepted every cycle. Configuration registers are written
// through cfg_we, cfg_index and cfg_wdata and must only be changed while no request
// is in flight.
module battery_power_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    bps_item_if.sink                      item,
    bps_result_if.source                  result,
    input  logic                          cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bps_pkg::CFG_W-1:0]     cfg_wdata
);

    bps_pkg::cfg_t cfg;

    bps_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    // Input register stage.
    logic                                in_valid_reg;
    bps_pkg::kind_t                      kind_reg;
    logic signed [bps_pkg::MV_W-1:0]     battery_mv_reg;
    logic [bps_pkg::LEVEL_W-1:0]         switch_level_reg;
    logic [bps_pkg::COUNT_W-1:0]         count_value_reg;

    // Sequencer state; its visible part doubles as the result register.
    logic                                out_valid_reg;
    logic                                power_reg, power_next;
    bps_pkg::mode_t                      mode_reg, mode_next;
    logic signed [bps_pkg::MV_W-1:0]     filter_reg, filter_next;
    logic [bps_pkg::COUNT_W-1:0]         sd_count_reg, sd_count_next;
    logic [bps_pkg::COUNT_W-1:0]         pu_count_reg, pu_count_next;
    logic                                sd_req_reg, sd_req_next;
    logic                                pu_req_reg, pu_req_next;
    logic [bps_pkg::SECONDS_W-1:0]       seconds_reg, seconds_next;

    logic                                advance;
    logic                                below_stay_on;
    logic signed [bps_pkg::MV_W-1:0]     filt_new;
    logic [bps_pkg::COUNT_W-1:0]         sd_tick;
    logic [bps_pkg::COUNT_W-1:0]         pu_tick;

    // The request in the input register moves into the state when the result
    // register is empty or its current result is taken in this cycle.
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            kind_reg         <= bps_pkg::kind_t'(item.kind);
            battery_mv_reg   <= item.battery_mv;
            switch_level_reg <= item.switch_level;
            count_value_reg  <= item.count_value;
        end
    end

    // The signed filtered level and the unsigned stay-on level compare as integers.
    assign below_stay_on = $signed({filter_reg[bps_pkg::MV_W-1], filter_reg})
                         < $signed({1'b0, cfg.stay_on_threshold_mv});
    assign filt_new = bps_pkg::filter_step(filter_reg, battery_mv_reg);
    assign sd_tick  = below_stay_on ? sd_count_reg - 1'b1 : sd_count_reg;
    assign pu_tick  = pu_count_reg - 1'b1;

    always_comb
    begin
        power_next    = power_reg;
        mode_next     = mode_reg;
        filter_next   = filter_reg;
        sd_count_next = sd_count_reg;
        pu_count_next = pu_count_reg;
        sd_req_next   = sd_req_reg;
        pu_req_next   = pu_req_reg;
        seconds_next  = seconds_reg;

        unique case (kind_reg)
            bps_pkg::KIND_TICK:
            begin
                seconds_next = seconds_reg + 1'b1;
                // A countdown already at zero stays there and raises nothing.
                if (power_reg)
                begin
                    if (sd_count_reg != '0)
                    begin
                        sd_count_next = sd_tick;
                        if (sd_tick == '0)
                        begin
                            sd_req_next = 1'b1;
                        end
                    end
                end
                else if (pu_count_reg != '0)
                begin
                    pu_count_next = pu_tick;
                    if (pu_tick == '0)
                    begin
                        pu_req_next = 1'b1;
                    end
                end
            end
            bps_pkg::KIND_SAMPLE:
            begin
                filter_next = filt_new;
                if (switch_level_reg < cfg.switch_off_limit)
                begin
                    mode_next   = bps_pkg::MODE_OFF;
                    power_next  = 1'b0;
                    pu_req_next = 1'b1;
                end
                else if (switch_level_reg < cfg.switch_on_limit)
                begin
                    mode_next     = bps_pkg::MODE_ALWAYS_ON;
                    power_next    = 1'b1;
                    pu_req_next   = 1'b1;
                    sd_count_next = cfg.default_shutdown_delay;
                end
                else
                begin
                    mode_next = bps_pkg::MODE_AUTO;
                    if (power_reg)
                    begin
                        // A low battery or a pending shutdown request turns power off;
                        // the request is consumed in the same step.
                        if (sd_req_reg || (filt_new < cfg.off_threshold_mv))
                        begin
                            sd_req_next   = 1'b0;
                            pu_req_next   = 1'b0;
                            pu_count_next = cfg.powerup_reload;
                            power_next    = 1'b0;
                        end
                    end
                    else if (pu_req_reg && (filt_new >= cfg.on_threshold_mv))
                    begin
                        pu_req_next   = 1'b0;
                        sd_req_next   = 1'b0;
                        sd_count_next = cfg.shutdown_reload;
                        power_next    = 1'b1;
                    end
                end
            end
            bps_pkg::KIND_LOAD_SHUTDOWN:
            begin
                sd_count_next = count_value_reg;
            end
            bps_pkg::KIND_LOAD_POWERUP:
            begin
                pu_count_next = count_value_reg;
            end
            default:
            begin
                pu_count_next = pu_count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            power_reg     <= 1'b0;
            mode_reg      <= bps_pkg::MODE_OFF;
            filter_reg    <= bps_pkg::ON_THRESHOLD_RST;
            sd_count_reg  <= bps_pkg::DEFAULT_DELAY_RST;
            pu_count_reg  <= bps_pkg::POWERUP_RELOAD_RST;
            sd_req_reg    <= 1'b0;
            pu_req_reg    <= 1'b0;
            seconds_reg   <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                power_reg     <= power_next;
                mode_reg      <= mode_next;
                filter_reg    <= filter_next;
                sd_count_reg  <= sd_count_next;
                pu_count_reg  <= pu_count_next;
                sd_req_reg    <= sd_req_next;
                pu_req_reg    <= pu_req_next;
                seconds_reg   <= seconds_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.power_on      = power_reg;
    assign result.switch_mode   = mode_reg;
    assign result.filtered_mv   = filter_reg;
    assign result.shutdown_left = sd_count_reg;
    assign result.powerup_left  = pu_count_reg;
    assign result.seconds       = seconds_reg;

    // Mode off always leaves power switched off, and only samples change power.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == bps_pkg::MODE_OFF) |-> !power_reg)
        else $error("power on while switch mode is off");

    // Always-on mode forces power on until another sample reclassifies the switch.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == bps_pkg::MODE_ALWAYS_ON) |-> power_reg)
        else $error("power off while switch mode is always on");

    // A stalled result keeps the request waiting in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !result.ready) |=> in_valid_reg && $stable(seconds_reg))
        else $error("request or state lost while result stalled");

    // The state only changes when a request moves through.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(sd_count_reg) && $stable(pu_count_reg) && $stable(filter_reg))
        else $error("state changed without a request");

endmodule
